// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: cond must hold whenever trig holds.
`define ASSERT_IMPL(lbl, clk, rst_n, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (trig) |-> (cond)) \
        else $error("assertion failed");

// Next-cycle implication: cond must hold in the cycle after trig.
`define ASSERT_NEXT(lbl, clk, rst_n, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (trig) |=> (cond)) \
        else $error("assertion failed");

`endif

// ===== hw/rtl/aicp_pkg.sv =====
// ----------------------------------------------------------------------------
// aicp_pkg
// Types and constants for the audio input control point.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package aicp_pkg;

    localparam int INSTANCES   = 4;
    localparam int INST_IDX_W  = (INSTANCES > 1) ? $clog2(INSTANCES) : 1;

    // stream widths
    localparam int S_TDATA_W   = 40;
    localparam int S_TUSER_W   = 1;
    localparam int M_TDATA_W   = 32;

    // configuration port
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam logic REG_GAIN_MIN = 1'b0;
    localparam logic REG_GAIN_MAX = 1'b1;

    localparam logic signed [7:0] GAIN_MIN_RST = -8'sd128;
    localparam logic signed [7:0] GAIN_MAX_RST = 8'sd127;

    // item kinds
    localparam logic KIND_CLIENT = 1'b0;
    localparam logic KIND_LOCAL  = 1'b1;

    // control-point opcodes
    localparam logic [7:0] OP_GAIN   = 8'd1;
    localparam logic [7:0] OP_UNMUTE = 8'd2;
    localparam logic [7:0] OP_MUTE   = 8'd3;
    localparam logic [7:0] OP_MANUAL = 8'd4;
    localparam logic [7:0] OP_AUTO   = 8'd5;

    // value lengths
    localparam logic [7:0] LEN_SHORT = 8'd2;
    localparam logic [7:0] LEN_GAIN  = 8'd3;
    localparam logic [7:0] LEN_LOCAL = 8'd4;

    // mute states
    localparam logic [1:0] MUTE_OFF      = 2'd0;
    localparam logic [1:0] MUTE_ON       = 2'd1;
    localparam logic [1:0] MUTE_DISABLED = 2'd2;

    // gain modes
    localparam logic [1:0] MODE_MANUAL_ONLY = 2'd0;
    localparam logic [1:0] MODE_AUTO_ONLY   = 2'd1;
    localparam logic [1:0] MODE_MANUAL      = 2'd2;
    localparam logic [1:0] MODE_AUTO        = 2'd3;

    // result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_OPCODE    = 3'd1;
    localparam logic [2:0] ST_SIZE      = 3'd2;
    localparam logic [2:0] ST_COUNTER   = 3'd3;
    localparam logic [2:0] ST_RANGE     = 3'd4;
    localparam logic [2:0] ST_MUTE_DIS  = 3'd5;
    localparam logic [2:0] ST_MODE_DENY = 3'd6;
    localparam logic [2:0] ST_HOST_REJ  = 3'd7;

    // controller to datapath commands
    typedef struct packed {
        logic capture;  // latch the input beat
        logic load;     // update the entry and load the output register
    } t_dp_cmd;

endpackage

// ===== hw/rtl/aicp_ctrl.sv =====
// ----------------------------------------------------------------------------
// aicp_ctrl
// Sequencer: capture a beat, execute it, hand the result to the output slot.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aicp_ctrl
    import aicp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    output logic    o_s_tready,
    output logic    o_m_tvalid,
    input  logic    i_m_tready,
    output t_dp_cmd o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic r_state, n_state;
    logic r_out_valid, n_out_valid;
    logic slot_free;

    assign slot_free  = !r_out_valid || i_m_tready;
    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;

    assign o_cmd.capture = i_s_tvalid && (r_state == S_IDLE);
    assign o_cmd.load    = (r_state == S_EXEC) && slot_free;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (o_cmd.capture) n_state = S_EXEC;
            S_EXEC: if (slot_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        priority if (o_cmd.load) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== hw/rtl/aicp_dp.sv =====
// ----------------------------------------------------------------------------
// aicp_dp
// Datapath: gain limit registers, per-instance state, rule check, result reg.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aicp_dp
    import aicp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    input  logic [S_TDATA_W-1:0]  i_s_tdata,
    input  logic [S_TUSER_W-1:0]  i_s_tuser,
    output logic [M_TDATA_W-1:0]  o_m_tdata,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic [APB_ADDR_W-1:0] i_paddr,
    input  logic [APB_DATA_W-1:0] i_pwdata,
    output logic [APB_DATA_W-1:0] o_prdata
);

    // configuration
    logic signed [7:0] r_gain_min, r_gain_max;
    logic              cfg_wr;

    // per-instance state
    logic signed [7:0] r_gain    [INSTANCES];
    logic [1:0]        r_mute    [INSTANCES];
    logic [1:0]        r_mode    [INSTANCES];
    logic [7:0]        r_counter [INSTANCES];

    // captured beat
    logic              r_kind;
    logic [1:0]        r_inst;
    logic [7:0]        r_op, r_len, r_cnt_in;
    logic signed [7:0] r_gain_in;
    logic [1:0]        r_mute_in, r_mode_in;
    logic              r_force, r_host_ok;

    // result register
    logic [2:0]        r_st;
    logic              r_fwd, r_ntf;
    logic [7:0]        r_g_out, r_c_out;
    logic [1:0]        r_mu_out, r_mo_out;

    // execute stage
    logic [INST_IDX_W-1:0] k;
    logic                  present;
    logic signed [7:0]     cur_g;
    logic [1:0]            cur_mu, cur_mo;
    logic [7:0]            cur_c;
    logic [2:0]            rule_st, st;
    logic                  ask, skip, fwd, ntf, we;
    logic signed [7:0]     n_gain;
    logic [1:0]            n_mute, n_mode;
    logic [7:0]            n_counter;

    assign cfg_wr = i_psel && i_penable && i_pwrite;

    // byte offsets inside a word are ignored
    always_comb begin
        unique case (i_paddr[2])
            REG_GAIN_MIN: o_prdata = APB_DATA_W'(r_gain_min);
            REG_GAIN_MAX: o_prdata = APB_DATA_W'(r_gain_max);
            default:      o_prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_min <= GAIN_MIN_RST;
            r_gain_max <= GAIN_MAX_RST;
        end else if (cfg_wr) begin
            if (i_paddr[2] == REG_GAIN_MIN) r_gain_min <= i_pwdata[7:0];
            if (i_paddr[2] == REG_GAIN_MAX) r_gain_max <= i_pwdata[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind    <= i_s_tuser[0];
            r_inst    <= i_s_tdata[1:0];
            r_op      <= i_s_tdata[9:2];
            r_len     <= i_s_tdata[17:10];
            r_cnt_in  <= i_s_tdata[25:18];
            r_gain_in <= i_s_tdata[33:26];
            r_mute_in <= i_s_tdata[35:34];
            r_mode_in <= i_s_tdata[37:36];
            r_force   <= i_s_tdata[38];
            r_host_ok <= i_s_tdata[39];
        end
    end

    assign k       = INST_IDX_W'(r_inst);
    assign present = (32'(r_inst) < INSTANCES);
    assign cur_g   = r_gain[k];
    assign cur_mu  = r_mute[k];
    assign cur_mo  = r_mode[k];
    assign cur_c   = r_counter[k];

    always_comb begin
        st        = ST_OK;
        rule_st   = ST_OK;
        ask       = 1'b0;
        skip      = 1'b0;
        fwd       = 1'b0;
        ntf       = 1'b0;
        we        = 1'b0;
        n_gain    = cur_g;
        n_mute    = cur_mu;
        n_mode    = cur_mo;
        n_counter = cur_c;

        if (r_kind == KIND_CLIENT) begin
            priority if (r_op == 8'd0 || r_op > OP_AUTO) begin
                st = ST_OPCODE;
            end else if (r_len < LEN_SHORT) begin
                st = ST_SIZE;
            end else if (r_cnt_in != cur_c) begin
                st = ST_COUNTER;
            end else if ((r_op == OP_GAIN && r_len != LEN_GAIN) ||
                         (r_op != OP_GAIN && r_len != LEN_SHORT)) begin
                st = ST_SIZE;
            end else begin
                unique case (r_op)
                    OP_GAIN: begin
                        if (r_gain_in > r_gain_max || r_gain_in < r_gain_min) begin
                            rule_st = ST_RANGE;
                        end else if (cur_mo == MODE_AUTO_ONLY || cur_mo == MODE_AUTO) begin
                            skip = 1'b1;  // automatic mode: ok, nothing stored
                        end else begin
                            ask = (r_gain_in != cur_g);
                        end
                        n_gain = r_gain_in;
                    end
                    OP_UNMUTE: begin
                        if (cur_mu == MUTE_DISABLED) rule_st = ST_MUTE_DIS;
                        ask    = (cur_mu == MUTE_ON);
                        n_mute = MUTE_OFF;
                    end
                    OP_MUTE: begin
                        if (cur_mu == MUTE_DISABLED) rule_st = ST_MUTE_DIS;
                        ask    = (cur_mu == MUTE_OFF);
                        n_mute = MUTE_ON;
                    end
                    OP_MANUAL: begin
                        if (cur_mo == MODE_MANUAL_ONLY || cur_mo == MODE_AUTO_ONLY)
                            rule_st = ST_MODE_DENY;
                        ask    = (cur_mo == MODE_AUTO);
                        n_mode = MODE_MANUAL;
                    end
                    default: begin
                        if (cur_mo == MODE_MANUAL_ONLY || cur_mo == MODE_AUTO_ONLY)
                            rule_st = ST_MODE_DENY;
                        ask    = (cur_mo == MODE_MANUAL);
                        n_mode = MODE_AUTO;
                    end
                endcase

                priority if (rule_st != ST_OK) begin
                    st = rule_st;
                end else if (skip) begin
                    st = ST_OK;
                end else if (ask && !r_host_ok) begin
                    st  = ST_HOST_REJ;
                    fwd = 1'b1;
                end else begin
                    fwd       = ask;
                    we        = 1'b1;
                    ntf       = 1'b1;
                    n_counter = cur_c + 8'd1;
                end
            end
        end else begin
            n_gain = r_gain_in;
            n_mute = r_mute_in;
            n_mode = r_mode_in;
            priority if (r_len != LEN_LOCAL) begin
                st = ST_SIZE;
            end else if (r_force) begin
                we        = 1'b1;
                ntf       = 1'b1;
                n_counter = r_cnt_in;
            end else if (cur_g != r_gain_in || cur_mu != r_mute_in ||
                         cur_mo != r_mode_in) begin
                we        = 1'b1;
                ntf       = 1'b1;
                n_counter = cur_c + 8'd1;
            end else begin
                we        = 1'b0;  // entry already matches
            end
        end

        // entry seen after the step
        if (!we) begin
            n_gain    = cur_g;
            n_mute    = cur_mu;
            n_mode    = cur_mo;
            n_counter = cur_c;
        end

        if (!present) begin
            st        = ST_OK;
            fwd       = 1'b0;
            ntf       = 1'b0;
            we        = 1'b0;
            n_gain    = '0;
            n_mute    = '0;
            n_mode    = '0;
            n_counter = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < INSTANCES; i++) begin
                r_gain[i]    <= '0;
                r_mute[i]    <= MUTE_OFF;
                r_mode[i]    <= MODE_MANUAL_ONLY;
                r_counter[i] <= '0;
            end
        end else if (i_cmd.load && we) begin
            r_gain[k]    <= n_gain;
            r_mute[k]    <= n_mute;
            r_mode[k]    <= n_mode;
            r_counter[k] <= n_counter;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_st     <= st;
            r_fwd    <= fwd;
            r_ntf    <= ntf;
            r_g_out  <= n_gain;
            r_mu_out <= n_mute;
            r_mo_out <= n_mode;
            r_c_out  <= n_counter;
        end
    end

    assign o_m_tdata = {7'd0, r_c_out, r_mo_out, r_mu_out, r_g_out, r_ntf, r_fwd, r_st};

endmodule

// ===== hw/rtl/audio_input_control_point.sv =====
// ----------------------------------------------------------------------------
// audio_input_control_point
// Gain, mute and gain-mode control point for four audio input instances.
// ----------------------------------------------------------------------------
// Each input beat is either a client control-point write or a local update
// from the host, addressed to one instance; it yields exactly one result beat
// with the status, forwarded and notify flags and the instance state after
// the step. The beat is captured first; then the addressed entry is read,
// checked and written back while the output register is loaded. The output
// register lets the next beat be taken while a result waits; a result still
// stalled when the next item executes holds that item in its execute state
// until the slot frees. The gain limits sit at byte address 0 (minimum) and
// 4 (maximum) and are shared by all instances.
`timescale 1ns / 1ps

module audio_input_control_point
    import aicp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // slave stream
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // instance_req[1:0], opcode[9:2], write_length[17:10], counter_in[25:18],
    // gain_in[33:26], mute_in[35:34], mode_in[37:36], force_counter[38],
    // host_accepts[39]
    input  logic [S_TDATA_W-1:0]  i_s_tdata,
    // kind[0]
    input  logic [S_TUSER_W-1:0]  i_s_tuser,
    // master stream
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // status[2:0], forwarded[3], notify[4], gain_out[12:5], mute_out[14:13],
    // mode_out[16:15], counter_out[24:17], zero fill[31:25]
    output logic [M_TDATA_W-1:0]  o_m_tdata,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    t_dp_cmd cmd;

    assign pready = 1'b1;

    aicp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (cmd)
    );

    aicp_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_s_tdata (i_s_tdata),
        .i_s_tuser (i_s_tuser),
        .o_m_tdata (o_m_tdata),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata)
    );

endmodule

// ===== hw/rtl/aicp_checker.sv =====
// ----------------------------------------------------------------------------
// aicp_checker
// Port-level checks for the audio input control point, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module aicp_checker
    import aicp_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_s_tvalid,
    input logic                 o_s_tready,
    input logic                 o_m_tvalid,
    input logic                 i_m_tready,
    input logic [M_TDATA_W-1:0] o_m_tdata
);

    logic       in_beat;
    logic [2:0] res_st;
    logic       res_fwd, res_ntf;

    assign in_beat = i_s_tvalid && o_s_tready;
    assign res_st  = o_m_tdata[2:0];
    assign res_fwd = o_m_tdata[3];
    assign res_ntf = o_m_tdata[4];

    // a stalled result beat holds
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready,
        o_m_tvalid && $stable(o_m_tdata))
    // one item in work at a time
    `ASSERT_NEXT(a_one_item, i_clk, i_rst_n, in_beat, !o_s_tready)
    // a failed step never raises notify
    `ASSERT_IMPL(a_err_no_ntf, i_clk, i_rst_n, o_m_tvalid && res_st != ST_OK, !res_ntf)
    // forwarding only ends in success or host rejection, and rejection needs it
    `ASSERT_IMPL(a_fwd_status, i_clk, i_rst_n, o_m_tvalid && res_fwd,
        res_st == ST_OK || res_st == ST_HOST_REJ)
    `ASSERT_IMPL(a_rej_fwd, i_clk, i_rst_n, o_m_tvalid && res_st == ST_HOST_REJ, res_fwd)

endmodule

bind audio_input_control_point aicp_checker u_aicp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

// ===== tb/aicp_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aicp_result_checker
// Predicts and checks the result stream of the audio input control point.
// ----------------------------------------------------------------------------
// Watches the input stream, the configuration port and the result stream.
// Each accepted input beat runs through a cycle-free model of the four
// instance entries and the shared gain limits. The model's result is queued
// and compared with the next result beat. Reports the mismatch count, the
// number of results still open and the modeled change counters. The
// stimulus uses the counters to build writes that get past the counter check.

module aicp_result_checker
    import aicp_pkg::*;
(
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    input  logic                            i_s_tready,
    input  logic [S_TDATA_W-1:0]            i_s_tdata,
    input  logic [S_TUSER_W-1:0]            i_s_tuser,
    input  logic                            i_m_tvalid,
    input  logic                            i_m_tready,
    input  logic [M_TDATA_W-1:0]            i_m_tdata,
    input  logic                            i_psel,
    input  logic                            i_penable,
    input  logic                            i_pwrite,
    input  logic [APB_ADDR_W-1:0]           i_paddr,
    input  logic [APB_DATA_W-1:0]           i_pwdata,
    input  logic                            i_pready,
    output int                              o_fail_count,
    output int                              o_open_count,
    output int                              o_checked,
    output logic [INSTANCES-1:0][7:0]       o_ctr_view
);

    // same bit order as the result tdata, lowest field last
    typedef struct packed {
        logic [7:0]        ctr;
        logic [1:0]        mode;
        logic [1:0]        mute;
        logic signed [7:0] gain;
        logic              ntf;
        logic              fwd;
        logic [2:0]        status;
    } ctl_result_t;

    logic signed [7:0] gain_tbl [INSTANCES];
    logic [1:0]        mute_tbl [INSTANCES];
    logic [1:0]        mode_tbl [INSTANCES];
    logic [7:0]        ctr_tbl  [INSTANCES];
    logic signed [7:0] gain_lo;
    logic signed [7:0] gain_hi;

    ctl_result_t expected_results [$];
    int          bad_cnt;
    int          seen_cnt;

    function automatic ctl_result_t apply_control_item(
        input logic              kind,
        input logic [1:0]        idx,
        input logic [7:0]        op,
        input logic [7:0]        len,
        input logic [7:0]        ctr,
        input logic signed [7:0] gain,
        input logic [1:0]        mute,
        input logic [1:0]        mode,
        input logic              ctr_force,
        input logic              host_ok
    );
        ctl_result_t r;
        logic        ask;
        logic        hold;
        r    = '0;
        ask  = 1'b0;
        hold = 1'b0;
        if (kind == KIND_CLIENT) begin
            if (op == 8'd0 || op > OP_AUTO) begin
                r.status = ST_OPCODE;
            end else if (len < LEN_SHORT) begin
                r.status = ST_SIZE;
            end else if (ctr != ctr_tbl[idx]) begin
                r.status = ST_COUNTER;
            end else if ((op == OP_GAIN && len != LEN_GAIN) ||
                         (op != OP_GAIN && len != LEN_SHORT)) begin
                r.status = ST_SIZE;
            end else begin
                case (op)
                    OP_GAIN: begin
                        if (gain > gain_hi || gain < gain_lo)
                            r.status = ST_RANGE;
                        else if (mode_tbl[idx] == MODE_AUTO_ONLY ||
                                 mode_tbl[idx] == MODE_AUTO)
                            hold = 1'b1;    // accepted, nothing stored
                        else
                            ask = (gain != gain_tbl[idx]);
                    end
                    OP_UNMUTE: begin
                        if (mute_tbl[idx] == MUTE_DISABLED)
                            r.status = ST_MUTE_DIS;
                        else
                            ask = (mute_tbl[idx] == MUTE_ON);
                    end
                    OP_MUTE: begin
                        if (mute_tbl[idx] == MUTE_DISABLED)
                            r.status = ST_MUTE_DIS;
                        else
                            ask = (mute_tbl[idx] == MUTE_OFF);
                    end
                    OP_MANUAL: begin
                        if (mode_tbl[idx] < MODE_MANUAL)
                            r.status = ST_MODE_DENY;
                        else
                            ask = (mode_tbl[idx] == MODE_AUTO);
                    end
                    default: begin
                        if (mode_tbl[idx] < MODE_MANUAL)
                            r.status = ST_MODE_DENY;
                        else
                            ask = (mode_tbl[idx] == MODE_MANUAL);
                    end
                endcase
                if (r.status == ST_OK && !hold) begin
                    if (ask) begin
                        r.fwd = 1'b1;
                        if (!host_ok)
                            r.status = ST_HOST_REJ;
                    end
                    if (r.status == ST_OK) begin
                        case (op)
                            OP_GAIN:   gain_tbl[idx] = gain;
                            OP_UNMUTE: mute_tbl[idx] = MUTE_OFF;
                            OP_MUTE:   mute_tbl[idx] = MUTE_ON;
                            OP_MANUAL: mode_tbl[idx] = MODE_MANUAL;
                            default:   mode_tbl[idx] = MODE_AUTO;
                        endcase
                        ctr_tbl[idx] = ctr_tbl[idx] + 8'd1;
                        r.ntf = 1'b1;
                    end
                end
            end
        end else begin
            if (len != LEN_LOCAL) begin
                r.status = ST_SIZE;
            end else if (ctr_force || gain_tbl[idx] != gain ||
                         mute_tbl[idx] != mute || mode_tbl[idx] != mode) begin
                gain_tbl[idx] = gain;
                mute_tbl[idx] = mute;
                mode_tbl[idx] = mode;
                ctr_tbl[idx]  = ctr_force ? ctr : ctr_tbl[idx] + 8'd1;
                r.ntf = 1'b1;
            end
        end
        r.gain = gain_tbl[idx];
        r.mute = mute_tbl[idx];
        r.mode = mode_tbl[idx];
        r.ctr  = ctr_tbl[idx];
        return r;
    endfunction

    task automatic log_mismatch(input string what, input ctl_result_t want,
                                input ctl_result_t got, input logic [6:0] fill);
        bad_cnt++;
        if (bad_cnt <= 10) begin
            $display("%0t mismatch, result %0d: %s", $realtime, seen_cnt, what);
            $display("   expected st=%0d fwd=%0d ntf=%0d gain=%0d mute=%0d mode=%0d ctr=%0d",
                     want.status, want.fwd, want.ntf, want.gain, want.mute, want.mode,
                     want.ctr);
            $display("   actual   st=%0d fwd=%0d ntf=%0d gain=%0d mute=%0d mode=%0d ctr=%0d"
                     , got.status, got.fwd, got.ntf, got.gain, got.mute, got.mode, got.ctr);
            if (fill != '0)
                $display("   nonzero fill bits 0x%0h", fill);
        end
    endtask

    always @(posedge i_clk) begin : watch
        ctl_result_t got;
        ctl_result_t want;
        if (!i_rst_n) begin
            for (int i = 0; i < INSTANCES; i++) begin
                gain_tbl[i] = '0;
                mute_tbl[i] = MUTE_OFF;
                mode_tbl[i] = MODE_MANUAL_ONLY;
                ctr_tbl[i]  = '0;
            end
            gain_lo = GAIN_MIN_RST;
            gain_hi = GAIN_MAX_RST;
            expected_results.delete();
            bad_cnt  = 0;
            seen_cnt = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr == {REG_GAIN_MIN, 2'b00})
                    gain_lo = i_pwdata[7:0];
                else if (i_paddr == {REG_GAIN_MAX, 2'b00})
                    gain_hi = i_pwdata[7:0];
            end
            // results leave only after their beat is captured and executed,
            // so checking before predicting keeps the queue order right
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata[24:0];
                if (expected_results.size() == 0) begin
                    want = '0;
                    log_mismatch("result beat with nothing outstanding", want, got,
                                 i_m_tdata[31:25]);
                end else begin
                    want = expected_results.pop_front();
                    if (got.status != want.status || got.fwd != want.fwd ||
                        got.ntf != want.ntf || got.gain != want.gain ||
                        got.mute != want.mute || got.mode != want.mode ||
                        got.ctr != want.ctr || i_m_tdata[31:25] != '0)
                        log_mismatch("field mismatch", want, got, i_m_tdata[31:25]);
                end
                seen_cnt++;
            end
            if (i_s_tvalid && i_s_tready)
                expected_results.push_back(apply_control_item(
                    i_s_tuser[0], i_s_tdata[1:0], i_s_tdata[9:2], i_s_tdata[17:10],
                    i_s_tdata[25:18], i_s_tdata[33:26], i_s_tdata[35:34],
                    i_s_tdata[37:36], i_s_tdata[38], i_s_tdata[39]));
        end
        o_fail_count <= bad_cnt;
        o_open_count <= expected_results.size();
        o_checked    <= seen_cnt;
        for (int i = 0; i < INSTANCES; i++)
            o_ctr_view[i] <= ctr_tbl[i];
    end

endmodule

// ===== tb/tb_audio_input_control_point.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_audio_input_control_point
// Stream-level test of the audio input control point.
// ----------------------------------------------------------------------------
// Drives a directed list of control-point writes and local updates that walks
// through every status code but the range error, then six random phases. Each
// phase starts with new gain limits: a narrow window, inverted limits, both at
// the low extreme, both at the high one, random, and the full range. Both
// stream sides idle at random. The first phases stall mostly the result side,
// the next the input side, the last none. The checker module predicts and
// compares. This module only drives stimulus and reports the verdict.

module tb_audio_input_control_point;
    import aicp_pkg::*;

    localparam int         CYCLE_LIMIT   = 400000;
    localparam int         PHASE_ITEMS   = 300;
    localparam logic [1:0] MUTE_RESERVED = 2'd3;  // stored, neither muted nor disabled
    localparam int         CTR_LIVE      = -1;    // take the instance's current counter

    typedef struct packed {
        logic              kind;
        logic              host_ok;
        logic              ctr_force;
        logic [1:0]        mode;
        logic [1:0]        mute;
        logic signed [7:0] gain;
        logic [7:0]        ctr;
        logic [7:0]        len;
        logic [7:0]        op;
        logic [1:0]        idx;
    } ctl_item_t;

    logic                      i_clk   = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [S_TDATA_W-1:0]      s_tdata = '0;
    logic [S_TUSER_W-1:0]      s_tuser = '0;
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [M_TDATA_W-1:0]      m_tdata;
    logic                      psel    = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0]     paddr   = '0;
    logic [APB_DATA_W-1:0]     pwdata  = '0;
    logic [APB_DATA_W-1:0]     prdata;
    logic                      pready;

    int                        fail_count;
    int                        open_count;
    int                        checked;
    logic [INSTANCES-1:0][7:0] ctr_view;

    int                        src_idle = 18;
    int                        dst_idle = 53;
    int                        cycles   = 0;
    int                        items_sent = 0;
    int                        cfg_writes = 0;
    logic signed [7:0]         lim_lo = GAIN_MIN_RST;
    logic signed [7:0]         lim_hi = GAIN_MAX_RST;

    audio_input_control_point DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    aicp_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_open_count (open_count),
        .o_checked    (checked),
        .o_ctr_view   (ctr_view)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        m_tready <= ($urandom_range(99) >= dst_idle);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results open", cycles, open_count);
            $display("TEST FAILED");
            $finish;
        end
    end

    // tvalid stays high into the next beat unless the sender idles first
    task automatic send_item(input ctl_item_t it);
        while ($urandom_range(99) < src_idle) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.kind;
        s_tdata  <= {it.host_ok, it.ctr_force, it.mode, it.mute, it.gain, it.ctr,
                     it.len, it.op, it.idx};
        @(posedge i_clk);
        while (!s_tready)
            @(posedge i_clk);
        items_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (open_count != 0)
            @(posedge i_clk);
    endtask

    task automatic write_limit(input logic sel, input logic signed [7:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= {{24{val[7]}}, val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg_writes++;
    endtask

    // one directed beat, then wait for its result so the counter view is current
    task automatic directed(input logic kind, input logic [1:0] idx,
                            input logic [7:0] op, input logic [7:0] len, input int ctr,
                            input logic signed [7:0] gain, input logic [1:0] mute,
                            input logic [1:0] mode, input logic ctr_force,
                            input logic host_ok);
        ctl_item_t it;
        it.kind      = kind;
        it.idx       = idx;
        it.op        = op;
        it.len       = len;
        it.ctr       = (ctr == CTR_LIVE) ? ctr_view[idx] : ctr[7:0];
        it.gain      = gain;
        it.mute      = mute;
        it.mode      = mode;
        it.ctr_force = ctr_force;
        it.host_ok   = host_ok;
        send_item(it);
        drain();
    endtask

    // Counters in the view lag by the beat accepted at this edge, so most
    // beats go to another instance than the one before to hit the counter check.
    function automatic ctl_item_t roll_item(input logic [1:0] prev);
        ctl_item_t  it;
        logic [1:0] hop;
        int         r;
        hop = 2'($urandom_range(1, 3));
        it.idx  = ($urandom_range(99) < 80) ? prev + hop : 2'($urandom_range(3));
        it.kind = ($urandom_range(99) < 25) ? KIND_LOCAL : KIND_CLIENT;
        it.op   = ($urandom_range(99) < 88) ? 8'($urandom_range(OP_GAIN, OP_AUTO))
                                            : 8'($urandom_range(255));
        if ($urandom_range(99) < 88)
            it.len = (it.kind == KIND_LOCAL) ? LEN_LOCAL
                   : (it.op == OP_GAIN) ? LEN_GAIN : LEN_SHORT;
        else if ($urandom_range(1))
            it.len = 8'($urandom_range(5));
        else
            it.len = 8'($urandom_range(255));
        it.ctr = ($urandom_range(99) < 88) ? ctr_view[it.idx] : 8'($urandom_range(255));
        r = $urandom_range(9);
        case (r)
            0:       it.gain = lim_lo;
            1:       it.gain = lim_hi;
            2:       it.gain = lim_lo - 8'sd1;
            3:       it.gain = lim_hi + 8'sd1;
            default: it.gain = 8'($urandom_range(255));
        endcase
        r = $urandom_range(99);
        it.mute = (r < 40) ? MUTE_OFF : (r < 70) ? MUTE_ON
                : (r < 88) ? MUTE_DISABLED : MUTE_RESERVED;
        r = $urandom_range(99);
        it.mode = (r < 20) ? MODE_MANUAL_ONLY : (r < 35) ? MODE_AUTO_ONLY
                : (r < 70) ? MODE_MANUAL : MODE_AUTO;
        it.ctr_force = ($urandom_range(99) < 30);
        it.host_ok   = ($urandom_range(99) < 75);
        return it;
    endfunction

    initial begin : stimulus
        ctl_item_t         it;
        logic [1:0]        prev;
        logic signed [7:0] lo;
        logic signed [7:0] hi;
        int                n_directed;
        prev = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // opcode, size and counter checks in their priority order
        directed(KIND_CLIENT, 2'd0, 8'd0,   LEN_SHORT, CTR_LIVE, 0, 0, 0, 0, 1);
        directed(KIND_CLIENT, 2'd0, 8'd6,   LEN_SHORT, CTR_LIVE, 0, 0, 0, 0, 1);
        directed(KIND_CLIENT, 2'd1, 8'd255, LEN_GAIN,  CTR_LIVE, 0, 0, 0, 0, 1);
        directed(KIND_CLIENT, 2'd0, OP_GAIN, 8'd1,     CTR_LIVE, 0, 0, 0, 0, 1);
        directed(KIND_CLIENT, 2'd0, OP_GAIN, LEN_GAIN, 77,       0, 0, 0, 0, 1);
        directed(KIND_CLIENT, 2'd0, OP_UNMUTE, LEN_GAIN, CTR_LIVE, 0, 0, 0, 0, 1);
        // gain: host rejects, accepts, repeat without asking, other extreme
        directed(KIND_CLIENT, 2'd0, OP_GAIN, LEN_GAIN, CTR_LIVE, 127, 0, 0, 0, 0);
        directed(KIND_CLIENT, 2'd0, OP_GAIN, LEN_GAIN, CTR_LIVE, 127, 0, 0, 0, 1);
        directed(KIND_CLIENT, 2'd0, OP_GAIN, LEN_GAIN, CTR_LIVE, 127, 0, 0, 0, 1);
        directed(KIND_CLIENT, 2'd0, OP_GAIN, LEN_GAIN, CTR_LIVE, -128, 0, 0, 0, 1);
        // mute and mode rules
        directed(KIND_CLIENT, 2'd0, OP_MUTE,   LEN_SHORT, CTR_LIVE, 0, 0, 0, 0, 1);
        directed(KIND_CLIENT, 2'd0, OP_MUTE,   LEN_SHORT, CTR_LIVE, 0, 0, 0, 0, 1);
        directed(KIND_CLIENT, 2'd0, OP_UNMUTE, LEN_SHORT, CTR_LIVE, 0, 0, 0, 0, 0);
        directed(KIND_CLIENT, 2'd0, OP_MANUAL, LEN_SHORT, CTR_LIVE, 0, 0, 0, 0, 1);
        // local updates: wrong size, change, no change
        directed(KIND_LOCAL, 2'd0, 8'd0, 8'd3, CTR_LIVE, 5, MUTE_DISABLED, MODE_AUTO, 0, 1);
        directed(KIND_LOCAL, 2'd0, 8'd0, LEN_LOCAL, CTR_LIVE, 5, MUTE_DISABLED, MODE_AUTO,
                 0, 1);
        directed(KIND_LOCAL, 2'd0, 8'd0, LEN_LOCAL, CTR_LIVE, 5, MUTE_DISABLED, MODE_AUTO,
                 0, 1);
        // automatic mode swallows gain, mute disabled, mode toggles via host
        directed(KIND_CLIENT, 2'd0, OP_GAIN,   LEN_GAIN,  CTR_LIVE, 9, 0, 0, 0, 1);
        directed(KIND_CLIENT, 2'd0, OP_MUTE,   LEN_SHORT, CTR_LIVE, 0, 0, 0, 0, 1);
        directed(KIND_CLIENT, 2'd0, OP_MANUAL, LEN_SHORT, CTR_LIVE, 0, 0, 0, 0, 1);
        directed(KIND_CLIENT, 2'd0, OP_AUTO,   LEN_SHORT, CTR_LIVE, 0, 0, 0, 0, 1);
        // forced counter at top of range, wrap, reserved mute value
        directed(KIND_LOCAL, 2'd3, 8'd0, LEN_LOCAL, 255, -1, MUTE_RESERVED, MODE_MANUAL,
                 1, 1);
        directed(KIND_CLIENT, 2'd3, OP_UNMUTE, LEN_SHORT, CTR_LIVE, 0, 0, 0, 0, 1);
        directed(KIND_LOCAL, 2'd3, 8'hFF, LEN_LOCAL, 255, -1, MUTE_RESERVED, MODE_MANUAL,
                 1, 0);
        directed(KIND_CLIENT, 2'd3, OP_MUTE, LEN_SHORT, CTR_LIVE, 0, 0, 0, 0, 1);
        n_directed = items_sent;

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0:       begin lo = -8'sd20;  hi = 8'sd20;    end
                1:       begin lo = 8'sd127;  hi = -8'sd128;  end
                2:       begin lo = -8'sd128; hi = -8'sd128;  end
                3:       begin lo = 8'sd127;  hi = 8'sd127;   end
                4: begin
                    lo = 8'($urandom_range(255));
                    hi = 8'($urandom_range(255));
                end
                default: begin lo = -8'sd128; hi = 8'sd127;   end
            endcase
            if (ph < 2) begin
                src_idle = 18;
                dst_idle = 53;
            end else if (ph < 4) begin
                src_idle = 53;
                dst_idle = 18;
            end else begin
                src_idle = 0;
                dst_idle = 0;
            end
            write_limit(REG_GAIN_MIN, lo);
            write_limit(REG_GAIN_MAX, hi);
            lim_lo = lo;
            lim_hi = hi;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                it = roll_item(prev);
                prev = it.idx;
                send_item(it);
            end
            drain();
        end

        repeat (8) @(posedge i_clk);
        $display("Sent %0d beats (%0d directed, rest random) under %0d limit writes,",
                 items_sent, n_directed, cfg_writes);
        $display("three stall mixes; %0d results checked, %0d mismatches",
                 checked, fail_count);
        if (fail_count == 0 && open_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/aicp_pkg.sv
hw/rtl/aicp_ctrl.sv
hw/rtl/aicp_dp.sv
hw/rtl/audio_input_control_point.sv
hw/rtl/aicp_checker.sv
tb/aicp_result_checker.sv
tb/tb_audio_input_control_point.sv
